// File: hw/rtl/cfpq_pkg.sv
`default_nettype none
package cfpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = 48;
  localparam int OUT_W       = 88;

  localparam logic [7:0] HDR_FIRST  = 8'hCC;
  localparam logic [7:0] HDR_SECOND = 8'hDD;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic [PTR_W-1:0] ptr_t;

  // queue slot: id in 7:0, index in 15:8, value in 47:16
  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  index;
    logic [7:0]  id;
  } entry_t;

  typedef struct packed {
    logic   done;
    logic   check_ok;
    entry_t entry;
  } frame_t;

endpackage
`default_nettype wire

// File: hw/rtl/cfpq_ram.sv
`default_nettype none
module cfpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cfpq_parser.sv
`default_nettype none
module cfpq_parser import cfpq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_en,
  input  wire logic [7:0] rx_byte,
  input  wire logic       burst_end,
  output frame_t          frame
);

  typedef enum logic [3:0] {
    PH_HUNT, PH_HDR2, PH_ID, PH_INDEX,
    PH_VAL0, PH_VAL1, PH_VAL2, PH_VAL3, PH_CHECK
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  accum_r, accum_nxt;
  entry_t      regs_r, regs_nxt;

  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r ^ rx_byte;
    regs_nxt  = regs_r;
    case (phase_r)
      PH_HUNT: begin
        accum_nxt = accum_r;
        if (rx_byte == HDR_FIRST) phase_nxt = PH_HDR2;
      end
      PH_HDR2: begin
        accum_nxt = accum_r;
        if (rx_byte == HDR_SECOND) begin
          phase_nxt = PH_ID;
          accum_nxt = '0;
        end else if (rx_byte != HDR_FIRST) begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_ID: begin
        regs_nxt.id = rx_byte;
        phase_nxt   = PH_INDEX;
      end
      PH_INDEX: begin
        regs_nxt.index = rx_byte;
        phase_nxt      = PH_VAL0;
      end
      PH_VAL0: begin
        regs_nxt.value[7:0] = rx_byte;
        phase_nxt           = PH_VAL1;
      end
      PH_VAL1: begin
        regs_nxt.value[15:8] = rx_byte;
        phase_nxt            = PH_VAL2;
      end
      PH_VAL2: begin
        regs_nxt.value[23:16] = rx_byte;
        phase_nxt             = PH_VAL3;
      end
      PH_VAL3: begin
        regs_nxt.value[31:24] = rx_byte;
        phase_nxt             = PH_CHECK;
      end
      default: begin
        accum_nxt = accum_r;
        phase_nxt = PH_HUNT;
      end
    endcase
    if (burst_end) phase_nxt = PH_HUNT;
  end

  assign frame.done     = byte_en && (phase_r == PH_CHECK);
  assign frame.check_ok = (accum_r == rx_byte);
  assign frame.entry    = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      accum_r <= '0;
      regs_r  <= '0;
    end else if (byte_en) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      regs_r  <= regs_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/command_frame_parser_queue_unit.sv
`default_nettype none
// a beat passes stage 1, then the output register; throughput: one beat per
// cycle unless the output stalls, pops and bytes in any mix; the queue memory
// has one write and one registered read port, a pop reads the tail slot
// reset (rst_n low, synchronous): parser hunts for a header, queue empty,
// drop count zero, no result pending; queue memory contents are not cleared
module command_frame_parser_queue_unit import cfpq_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // rx_byte
  input  wire logic             in_tuser,   // op
  input  wire logic             in_tlast,   // burst_end
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // frame_accepted, frame_bad_check, frame_dropped, pop_valid, cmd_id,
  // cmd_index, cmd_value, queue_count, drop_total
  output logic [OUT_W-1:0]      out_tdata
);

  logic   in_acc, pop_en, byte_en, push, drop, pop_hit, s1_load, s2_load;
  frame_t frame;
  entry_t rd_entry;

  ptr_t        head_r, head_nxt, tail_r, tail_nxt;
  logic [31:0] drops_r, drops_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W+3:0] count_ext;

  logic        s1_valid_r, s1_acc_r, s1_bad_r, s1_drop_r, s1_pop_r;
  logic [3:0]  s1_count_r;
  logic [31:0] s1_drops_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  function automatic ptr_t next_slot(input ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_acc  = in_tvalid && in_tready;
  assign pop_en  = in_acc && (in_tuser == OP_POP);
  assign byte_en = in_acc && (in_tuser == OP_BYTE);

  cfpq_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .rx_byte   (in_tdata),
    .burst_end (in_tlast),
    .frame     (frame)
  );

  assign pop_hit = pop_en && (head_r != tail_r);
  assign push    = frame.done && frame.check_ok && (next_slot(head_r) != tail_r);
  assign drop    = frame.done && frame.check_ok && (next_slot(head_r) == tail_r);

  always_comb begin
    head_nxt  = push ? next_slot(head_r) : head_r;
    tail_nxt  = pop_hit ? next_slot(tail_r) : tail_r;
    drops_nxt = drop ? drops_r + 32'd1 : drops_r;
    count_nxt = CNT_W'(head_nxt) - CNT_W'(tail_nxt)
              + ((head_nxt < tail_nxt) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(0));
    count_ext = {4'd0, count_nxt};
  end

  // a slot written by one beat is read at the earliest by the next beat
  cfpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (push),
    .waddr (head_r),
    .wdata (frame.entry),
    .re    (pop_hit),
    .raddr (tail_r),
    .rdata (rd_entry)
  );

  // stage 1 waits on the memory read, stage 2 is the output register
  assign s2_load   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s2_load;
  assign s1_load   = in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      drops_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      drops_r <= drops_nxt;
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_acc_r   <= push;
      s1_bad_r   <= frame.done && !frame.check_ok;
      s1_drop_r  <= drop;
      s1_pop_r   <= pop_hit;
      s1_count_r <= count_ext[3:0];
      s1_drops_r <= drops_nxt;
    end
    if (s2_load) begin
      out_data_r <= {s1_drops_r, s1_count_r,
                     s1_pop_r ? rd_entry : entry_t'('0),
                     s1_pop_r, s1_drop_r, s1_bad_r, s1_acc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
